/* sv/sanm_pkg.sv */
// ----------------------------------------------------------------------------
// sanm_pkg
// Shared types, register codes and helpers for the stick auto-repeat menu
// navigator.
// ----------------------------------------------------------------------------
package sanm_pkg;

  // Default width of the option index.
  localparam int INDEX_WIDTH_DEF = 8;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INDEX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_ENABLE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NAV_MODE        = 3'd5;

  // Register reset values.
  localparam logic [6:0] DEAD_ZONE_RST       = 7'd12;
  localparam logic [6:0] INITIAL_DELAY_RST   = 7'd9;
  localparam logic [6:0] REPEAT_INTERVAL_RST = 7'd2;
  localparam logic [7:0] MAX_INDEX_RST       = 8'd0;

  // Extra frames between the first and second repeat in staggered mode.
  localparam logic [8:0] STAGGER_OFFSET = 9'd3;

  // Navigation modes.
  typedef enum logic [1:0] {
    NAV_HORIZ = 2'd0,
    NAV_VSLOW = 2'd1,
    NAV_VFAST = 2'd2,
    NAV_VSTAG = 2'd3
  } nav_mode_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [6:0] dead_zone;
    logic [6:0] initial_delay;
    logic [6:0] repeat_interval;
    logic [7:0] max_index;
    logic       wrap_enable;
    nav_mode_t  nav_mode;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       stepped;
    logic [7:0] held_count;
    logic [7:0] option_index;
  } res_t;

  // Magnitude of a signed 8-bit sample; -128 gives 128.
  function automatic logic [7:0] mag8(input logic [7:0] v);
    mag8 = v[7] ? (~v + 8'd1) : v;
  endfunction

  // True when the sample lies beyond the dead zone.
  function automatic logic beyond(input logic [7:0] v, input logic [6:0] dz);
    beyond = mag8(v) > {1'b0, dz};
  endfunction

endpackage

/* sv/sanm_core.sv */
// ----------------------------------------------------------------------------
// sanm_core
// Held-frames counter, previous-sample memory and option index update.
// Computes one frame's result from the registered sample and the state,
// and commits the new state when the frame advances.
// ----------------------------------------------------------------------------
module sanm_core #(
  parameter int INDEX_WIDTH = sanm_pkg::INDEX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic [7:0]        stick_x,
  input  logic [7:0]        stick_y,
  input  sanm_pkg::cfg_t    cfg,
  output sanm_pkg::res_t    res
);

  localparam logic [8:0] STAGGER_OFS = sanm_pkg::STAGGER_OFFSET;

  logic [7:0]             held_r, held_nxt;
  logic [7:0]             prev_x_r, prev_y_r;
  logic [INDEX_WIDTH-1:0] cur_r, cur_nxt;

  logic       x_beyond, y_beyond, px_beyond, py_beyond;
  logic       x_pos, x_neg, y_pos, y_neg, px_pos, px_neg, py_pos, py_neg;
  logic       rev_x, rev_y;
  logic [7:0] held_cnt;
  logic [8:0] h9, d9, limit9;
  logic [7:0] reload;
  logic       dir_pos, dir_neg, trig;

  logic [INDEX_WIDTH-1:0] maxi;
  logic [INDEX_WIDTH:0]   idx_sum, maxe;

  // Sign and dead-zone tests of the current and previous samples.
  always_comb begin
    x_beyond  = sanm_pkg::beyond(stick_x, cfg.dead_zone);
    y_beyond  = sanm_pkg::beyond(stick_y, cfg.dead_zone);
    px_beyond = sanm_pkg::beyond(prev_x_r, cfg.dead_zone);
    py_beyond = sanm_pkg::beyond(prev_y_r, cfg.dead_zone);
    x_neg  = stick_x[7];
    x_pos  = !stick_x[7] && (stick_x != 8'd0);
    y_neg  = stick_y[7];
    y_pos  = !stick_y[7] && (stick_y != 8'd0);
    px_neg = prev_x_r[7];
    px_pos = !prev_x_r[7] && (prev_x_r != 8'd0);
    py_neg = prev_y_r[7];
    py_pos = !prev_y_r[7] && (prev_y_r != 8'd0);
    rev_x  = ((x_pos && px_neg) || (x_neg && px_pos)) && px_beyond;
    rev_y  = ((y_pos && py_neg) || (y_neg && py_pos)) && py_beyond;
  end

  // Held-frames counter with saturation, dead-zone and reversal clear, and repeat reload.
  always_comb begin
    if (x_beyond || y_beyond) begin
      held_cnt = (held_r == 8'hFF) ? held_r : held_r + 8'd1;
      if (rev_x || rev_y) begin
        held_cnt = 8'd0;
      end
    end else begin
      held_cnt = 8'd0;
    end
    d9     = {2'b00, cfg.initial_delay};
    limit9 = d9 + {2'b00, cfg.repeat_interval};
    reload = (cfg.initial_delay != 7'd0) ? ({1'b0, cfg.initial_delay} - 8'd1) : 8'd0;
    held_nxt = ({1'b0, held_cnt} >= limit9) ? reload : held_cnt;
    h9 = {1'b0, held_nxt};
  end

  // Step direction and trigger for the selected mode.
  always_comb begin
    if (cfg.nav_mode == sanm_pkg::NAV_HORIZ) begin
      dir_pos = x_beyond && x_pos;
      dir_neg = x_beyond && x_neg;
    end else begin
      // Up is toward the top of the list, so it decrements.
      dir_pos = y_beyond && y_neg;
      dir_neg = y_beyond && y_pos;
    end
    unique case (cfg.nav_mode)
      sanm_pkg::NAV_VFAST: trig = (h9 == 9'd1) || ((h9 + 9'd1) >= d9);
      sanm_pkg::NAV_VSTAG: trig = (h9 == 9'd1) || (h9 == d9) || (h9 == d9 + STAGGER_OFS);
      default:             trig = (h9 == 9'd1) || (h9 == d9);
    endcase
  end

  // Index step with wrap or clamp at the ends.
  always_comb begin
    maxi    = INDEX_WIDTH'(cfg.max_index);
    maxe    = {1'b0, maxi};
    idx_sum = {1'b0, cur_r};
    if (dir_pos) begin
      idx_sum = {1'b0, cur_r} + (INDEX_WIDTH+1)'(1);
    end else if (dir_neg) begin
      idx_sum = {1'b0, cur_r} - (INDEX_WIDTH+1)'(1);
    end
    cur_nxt = cur_r;
    if (trig) begin
      if (dir_neg && (cur_r == '0)) begin
        cur_nxt = cfg.wrap_enable ? maxi : '0;
      end else if (idx_sum > maxe) begin
        cur_nxt = cfg.wrap_enable ? '0 : maxi;
      end else begin
        cur_nxt = idx_sum[INDEX_WIDTH-1:0];
      end
    end
    res.option_index = 8'(cur_nxt);
    res.held_count   = held_nxt;
    res.stepped      = trig && (dir_pos || dir_neg);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= 8'd0;
      prev_x_r <= 8'd0;
      prev_y_r <= 8'd0;
      cur_r    <= '0;
    end else if (advance) begin
      held_r   <= held_nxt;
      prev_x_r <= stick_x;
      prev_y_r <= stick_y;
      cur_r    <= cur_nxt;
    end
  end

endmodule

/* sv/stick_autorepeat_menu_nav.sv */
// ----------------------------------------------------------------------------
// stick_autorepeat_menu_nav
// Joystick dead-zone and typematic auto-repeat menu navigator.
// An accepted sample passes the sample register and the result register.
// Throughput: 1 sample per cycle while out_tready does not stall the result.
// Reset (rst_n low, synchronous): registers return to their defaults,
// the counter, previous sample and option index clear, both stages empty.
// ----------------------------------------------------------------------------
module stick_autorepeat_menu_nav #(
  parameter int INDEX_WIDTH = sanm_pkg::INDEX_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [15:0]                      in_tdata,   // stick_x[7:0], stick_y[15:8]
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // option_index[7:0],
                                                       // held_count[15:8], stepped[16]
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [sanm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sanm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  sanm_pkg::cfg_t cfg_r;
  sanm_pkg::res_t core_res, out_res_r;

  logic       s1_valid_r, out_valid_r;
  logic [7:0] s1_x_r, s1_y_r;
  logic       out_free, s1_adv, in_acc;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dead_zone       <= sanm_pkg::DEAD_ZONE_RST;
      cfg_r.initial_delay   <= sanm_pkg::INITIAL_DELAY_RST;
      cfg_r.repeat_interval <= sanm_pkg::REPEAT_INTERVAL_RST;
      cfg_r.max_index       <= sanm_pkg::MAX_INDEX_RST;
      cfg_r.wrap_enable     <= 1'b0;
      cfg_r.nav_mode        <= sanm_pkg::NAV_HORIZ;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sanm_pkg::REG_DEAD_ZONE:       cfg_r.dead_zone       <= cfg_wdata[6:0];
        sanm_pkg::REG_INITIAL_DELAY:   cfg_r.initial_delay   <= cfg_wdata[6:0];
        sanm_pkg::REG_REPEAT_INTERVAL: cfg_r.repeat_interval <= cfg_wdata[6:0];
        sanm_pkg::REG_MAX_INDEX:       cfg_r.max_index       <= cfg_wdata;
        sanm_pkg::REG_WRAP_ENABLE:     cfg_r.wrap_enable     <= cfg_wdata[0];
        sanm_pkg::REG_NAV_MODE:        cfg_r.nav_mode        <= sanm_pkg::nav_mode_t'(cfg_wdata[1:0]);
        default: ;
      endcase
    end
  end

  // Flow control: the sample stage moves when the result register is free.
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // Sample register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_x_r <= in_tdata[7:0];
      s1_y_r <= in_tdata[15:8];
    end
  end

  sanm_core #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_adv),
    .stick_x (s1_x_r),
    .stick_y (s1_y_r),
    .cfg     (cfg_r),
    .res     (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= core_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.stepped, out_res_r.held_count, out_res_r.option_index};

endmodule

/* sv/sanm_checker.sv */
// ----------------------------------------------------------------------------
// sanm_checker
// Port-level checks of the menu navigator's streams, bound to the top level.
// ----------------------------------------------------------------------------
module sanm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // With no result waiting the block always takes a sample.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // An accepted sample is followed by a valid result once it has passed the sample and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> ##1 out_tvalid)
    else $error("result missing after accepted sample");

endmodule

bind stick_autorepeat_menu_nav sanm_checker u_sanm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
